>>> hdl/csr_sparse_matrix_vector_defines.svh
// Assertion macros for the CSR sparse matrix-vector block.
`ifndef CSR_SPARSE_MATRIX_VECTOR_DEFINES_SVH
`define CSR_SPARSE_MATRIX_VECTOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/csr_spmv_pkg.sv
package csr_spmv_pkg;

	// dense vector store depth and its address width
	localparam int VEC_DEPTH = 4096;
	localparam int VEC_AW    = $clog2(VEC_DEPTH);

	localparam int IDX_W = 12;
	localparam int VAL_W = 32;
	localparam int ACC_W = 64;
	localparam int FRAC  = 16;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_NONZERO = 2'd1,
		OP_CLOSE   = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	localparam logic signed [VAL_W-1:0] SUM_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] SUM_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

>>> hdl/csr_sparse_matrix_vector.sv
// CSR sparse matrix times dense vector, Q16.16. Load the vector first with
// load items (opcode 0, index, value); an element must be written before a
// nonzero reads it. Then stream the matrix in CSR order: each nonzero item
// (opcode 1, column, value) multiplies value by the stored element, shifts the
// Q32.32 product down to Q16.16 (floor) and adds it to a 64-bit row sum that
// saturates at the signed 64-bit limits. A nonzero with row_end set, or a
// close item (opcode 2, for an empty row), emits one result: the row number
// (counts emitted rows, wraps at 4096), the sum clamped to 32 bits and a flag
// set when clamping changed it; the sum then restarts at zero. Columns at or
// beyond the store depth read as zero and loads there are dropped; opcode 3
// is ignored. Rate: one item per cycle sustained, loads included, with no
// result stall. A nonzero passes from acceptance to a valid result through
// the registered read of the vector store, the 32x32 multiplier register, the
// accumulator register (which feeds its own sum straight to the next item, so
// back-to-back nonzeros of one row never wait) and the output register. Back
// pressure on the result side stalls only full stages; bubbles are filled first.
`include "csr_sparse_matrix_vector_defines.svh"

module csr_sparse_matrix_vector (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             opcode,
	input  logic [csr_spmv_pkg::IDX_W-1:0]         index,
	input  logic signed [csr_spmv_pkg::VAL_W-1:0]  value,
	input  logic                                   row_end,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [csr_spmv_pkg::IDX_W-1:0]         row_index,
	output logic signed [csr_spmv_pkg::VAL_W-1:0]  row_sum,
	output logic                                   saturated
);

	// ---------------- input decode ----------------
	csr_spmv_pkg::opcode_t op_in;
	logic accept;
	logic in_rng;
	logic [csr_spmv_pkg::VEC_AW-1:0] vaddr;

	assign op_in  = csr_spmv_pkg::opcode_t'(opcode);
	assign accept = in_valid && in_ready;
	// index compared at full width so any store depth works
	assign in_rng = (32'(index) < 32'(csr_spmv_pkg::VEC_DEPTH));
	assign vaddr  = csr_spmv_pkg::VEC_AW'(index);

	// ---------------- pipeline control ----------------
	// Only nonzero and close items travel down the pipe; loads finish at
	// acceptance (store write) and opcode 3 is dropped.
	logic v1_s1, v2_s2, v3_s3, out_valid_q;
	logic emit_s2;
	logic o_free, s3_free, s2_fire, s2_free, s1_fire, s1_free;

	assign o_free  = !out_valid_q || out_ready;
	assign s3_free = !v3_s3 || o_free;
	assign s2_fire = v2_s2 && (!emit_s2 || s3_free);
	assign s2_free = !v2_s2 || s2_fire;
	assign s1_fire = v1_s1 && s2_free;
	assign s1_free = !v1_s1 || s1_fire;
	assign in_ready = s1_free;

	// ---------------- vector store ----------------
	logic signed [csr_spmv_pkg::VAL_W-1:0] vmem [csr_spmv_pkg::VEC_DEPTH];
	logic signed [csr_spmv_pkg::VAL_W-1:0] rd_q;

	// read data only reloads on acceptance, so it holds while stage 1 stalls
	always_ff @(posedge clk) begin
		if (accept && op_in == csr_spmv_pkg::OP_LOAD && in_rng)
			vmem[vaddr] <= value;
		if (accept && op_in == csr_spmv_pkg::OP_NONZERO)
			rd_q <= vmem[vaddr];
	end

	// ---------------- stage 1: store read ----------------
	logic signed [csr_spmv_pkg::VAL_W-1:0] val_s1;
	logic nz_s1, rng_s1, last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v1_s1 <= 1'b0;
		else if (s1_free)
			v1_s1 <= accept && (op_in == csr_spmv_pkg::OP_NONZERO ||
				op_in == csr_spmv_pkg::OP_CLOSE);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_s1  <= value;
			nz_s1   <= (op_in == csr_spmv_pkg::OP_NONZERO);
			rng_s1  <= in_rng;
			last_s1 <= row_end;
		end
	end

	// out-of-range columns and close items contribute nothing
	logic signed [csr_spmv_pkg::VAL_W-1:0] xb_s1;
	logic signed [csr_spmv_pkg::ACC_W-1:0] mult_s1;

	assign xb_s1   = (nz_s1 && rng_s1) ? rd_q : '0;
	assign mult_s1 = val_s1 * xb_s1;

	// ---------------- stage 2: product ----------------
	logic signed [csr_spmv_pkg::ACC_W-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v2_s2 <= 1'b0;
		else if (s2_free)
			v2_s2 <= s1_fire;
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			prod_s2 <= mult_s1;
			emit_s2 <= !nz_s1 || last_s1;
		end
	end

	// Q32.32 -> Q16.16 floor, then saturating add into the row sum
	logic signed [csr_spmv_pkg::ACC_W-1:0] acc_q;
	logic signed [csr_spmv_pkg::ACC_W-1:0] prod_sh;
	logic signed [csr_spmv_pkg::ACC_W:0]   sum_ext;
	logic signed [csr_spmv_pkg::ACC_W-1:0] sum_sat;
	logic [csr_spmv_pkg::IDX_W-1:0]        row_cnt_q;

	assign prod_sh = prod_s2 >>> csr_spmv_pkg::FRAC;
	assign sum_ext = {acc_q[csr_spmv_pkg::ACC_W-1], acc_q} +
		{prod_sh[csr_spmv_pkg::ACC_W-1], prod_sh};

	always_comb begin
		if (sum_ext[csr_spmv_pkg::ACC_W] == sum_ext[csr_spmv_pkg::ACC_W-1])
			sum_sat = sum_ext[csr_spmv_pkg::ACC_W-1:0];
		else if (sum_ext[csr_spmv_pkg::ACC_W])
			sum_sat = csr_spmv_pkg::ACC_MIN;
		else
			sum_sat = csr_spmv_pkg::ACC_MAX;
	end

	// accumulator is its own forwarding path: next item sees it next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			row_cnt_q <= '0;
		end else if (s2_fire) begin
			acc_q <= emit_s2 ? '0 : sum_sat;
			if (emit_s2)
				row_cnt_q <= row_cnt_q + csr_spmv_pkg::IDX_W'(1);
		end
	end

	// ---------------- stage 3: row result ----------------
	logic signed [csr_spmv_pkg::ACC_W-1:0] sum_s3;
	logic [csr_spmv_pkg::IDX_W-1:0]        row_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v3_s3 <= 1'b0;
		else if (s3_free)
			v3_s3 <= s2_fire && emit_s2;
	end

	always_ff @(posedge clk) begin
		if (s2_fire && emit_s2) begin
			sum_s3 <= sum_sat;
			row_s3 <= row_cnt_q;
		end
	end

	// clamp to 32 bits: fits when the top 33 bits agree
	logic fits_s3;
	logic signed [csr_spmv_pkg::VAL_W-1:0] clamp_s3;

	assign fits_s3 = (&sum_s3[csr_spmv_pkg::ACC_W-1:csr_spmv_pkg::VAL_W-1]) ||
		!(|sum_s3[csr_spmv_pkg::ACC_W-1:csr_spmv_pkg::VAL_W-1]);

	always_comb begin
		if (fits_s3)
			clamp_s3 = sum_s3[csr_spmv_pkg::VAL_W-1:0];
		else if (sum_s3[csr_spmv_pkg::ACC_W-1])
			clamp_s3 = csr_spmv_pkg::SUM_MIN;
		else
			clamp_s3 = csr_spmv_pkg::SUM_MAX;
	end

	// ---------------- output register ----------------
	logic [csr_spmv_pkg::IDX_W-1:0]        row_q;
	logic signed [csr_spmv_pkg::VAL_W-1:0] sum_q;
	logic                                  sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (o_free)
			out_valid_q <= v3_s3;
	end

	always_ff @(posedge clk) begin
		if (o_free && v3_s3) begin
			row_q <= row_s3;
			sum_q <= clamp_s3;
			sat_q <= !fits_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = row_q;
	assign row_sum   = sum_q;
	assign saturated = sat_q;

	// ---------------- assertions ----------------
	`ASSERT_IMP(a_sat_rail, clk, arst_n, out_valid_q && sat_q,
		sum_q == csr_spmv_pkg::SUM_MAX || sum_q == csr_spmv_pkg::SUM_MIN)
	`ASSERT_NXT(a_row_step, clk, arst_n, s2_fire && emit_s2,
		row_cnt_q == 12'($past(row_cnt_q) + 12'd1))
	`ASSERT_NXT(a_acc_clear, clk, arst_n, s2_fire && emit_s2, acc_q == '0)
	`ASSERT_NXT(a_s3_hold, clk, arst_n, v3_s3 && !o_free,
		v3_s3 && $stable(sum_s3) && $stable(row_s3))

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

// Stream-level check of the CSR sparse matrix-vector block.
// An initial block builds the whole item stream up front: vector loads, CSR rows,
// empty-row closes and some noise. A falling-edge driver presents the items in
// bursts. A rising-edge monitor runs every accepted item through a Q16.16
// predictor and checks each result against the oldest expected row.
module testbench;

	typedef struct {
		csr_spmv_pkg::opcode_t                      op;
		logic [csr_spmv_pkg::IDX_W-1:0]             idx;
		logic signed [csr_spmv_pkg::VAL_W-1:0]      val;
		logic                                       last;
	} stream_item_t;

	typedef struct {
		logic [csr_spmv_pkg::IDX_W-1:0]             row;
		logic signed [csr_spmv_pkg::VAL_W-1:0]      sum;
		logic                                       sat;
	} row_result_t;

	// ports; every input starts at a known value
	logic                                   clk       = 1'b0;
	logic                                   arst_n    = 1'b0;
	logic                                   in_valid  = 1'b0;
	logic                                   in_ready;
	logic [1:0]                             opcode    = '0;
	logic [csr_spmv_pkg::IDX_W-1:0]         index     = '0;
	logic signed [csr_spmv_pkg::VAL_W-1:0]  value     = '0;
	logic                                   row_end   = 1'b0;
	logic                                   out_valid;
	logic                                   out_ready = 1'b0;
	logic [csr_spmv_pkg::IDX_W-1:0]         row_index;
	logic signed [csr_spmv_pkg::VAL_W-1:0]  row_sum;
	logic                                   saturated;

	csr_sparse_matrix_vector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.index     (index),
		.value     (value),
		.row_end   (row_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_index (row_index),
		.row_sum   (row_sum),
		.saturated (saturated)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stimulus bookkeeping, used only while the stream is being built.
	stream_item_t  matrix_stream_q[$];
	bit            vec_written[csr_spmv_pkg::VEC_DEPTH];
	int            written_cols[$];
	int            items_made;

	// Predictor state: its own copy of the vector, the row sum and the row number.
	logic signed [csr_spmv_pkg::VAL_W-1:0]  vec_mem[csr_spmv_pkg::VEC_DEPTH];
	logic signed [csr_spmv_pkg::ACC_W-1:0]  row_acc = '0;
	logic [csr_spmv_pkg::IDX_W-1:0]         row_cnt = '0;
	row_result_t                            row_results_q[$];

	int  mismatches;
	bit  item_taken;

	task automatic report_mismatch(input string msg);
		if (mismatches < 100)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Clamp the 64-bit sum to 32 bits, queue the row result, then start a new row.
	task automatic emit_row_result();
		row_result_t r;
		r.row = row_cnt;
		r.sat = 1'b0;
		if (row_acc > csr_spmv_pkg::SUM_MAX) begin
			r.sum = csr_spmv_pkg::SUM_MAX;
			r.sat = 1'b1;
		end else if (row_acc < csr_spmv_pkg::SUM_MIN) begin
			r.sum = csr_spmv_pkg::SUM_MIN;
			r.sat = 1'b1;
		end else begin
			r.sum = row_acc[csr_spmv_pkg::VAL_W-1:0];
		end
		row_results_q.push_back(r);
		row_acc = '0;
		row_cnt = row_cnt + csr_spmv_pkg::IDX_W'(1);
	endtask

	// Apply one accepted item to the predictor state.
	task automatic accumulate_row(input stream_item_t it);
		logic signed [csr_spmv_pkg::ACC_W-1:0]  prod;
		logic signed [csr_spmv_pkg::ACC_W:0]    wide;
		case (it.op)
			csr_spmv_pkg::OP_LOAD:
				vec_mem[it.idx] = it.val;
			csr_spmv_pkg::OP_NONZERO: begin
				// exact Q32.32 product, floored down to Q16.16
				prod = csr_spmv_pkg::ACC_W'(it.val) *
					csr_spmv_pkg::ACC_W'(vec_mem[it.idx]);
				prod = prod >>> csr_spmv_pkg::FRAC;
				wide = {row_acc[csr_spmv_pkg::ACC_W-1], row_acc} +
					{prod[csr_spmv_pkg::ACC_W-1], prod};
				if (wide[csr_spmv_pkg::ACC_W] != wide[csr_spmv_pkg::ACC_W-1])
					row_acc = wide[csr_spmv_pkg::ACC_W] ? csr_spmv_pkg::ACC_MIN :
						csr_spmv_pkg::ACC_MAX;
				else
					row_acc = wide[csr_spmv_pkg::ACC_W-1:0];
				if (it.last)
					emit_row_result();
			end
			csr_spmv_pkg::OP_CLOSE:
				emit_row_result();
			default: ;
		endcase
	endtask

	task automatic push_item(input csr_spmv_pkg::opcode_t op, input int idx,
			input logic signed [csr_spmv_pkg::VAL_W-1:0] val, input logic last);
		stream_item_t it;
		it.op   = op;
		it.idx  = idx[csr_spmv_pkg::IDX_W-1:0];
		it.val  = val;
		it.last = last;
		matrix_stream_q.push_back(it);
		if (op == csr_spmv_pkg::OP_LOAD && !vec_written[idx]) begin
			vec_written[idx] = 1'b1;
			written_cols.push_back(idx);
		end
		if (op != csr_spmv_pkg::OP_NONE)
			items_made++;
	endtask

	// Columns are only ever drawn from elements that were already loaded.
	function automatic int pick_col();
		return written_cols[$urandom_range(0, written_cols.size() - 1)];
	endfunction

	// Mostly modest Q16.16 magnitudes so that sums rarely clip, plus
	// full-range values and the corner values.
	function automatic logic signed [csr_spmv_pkg::VAL_W-1:0] pick_q16();
		logic signed [csr_spmv_pkg::VAL_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom;
			2: begin
				case ($urandom_range(0, 4))
					0: v = csr_spmv_pkg::SUM_MAX;
					1: v = csr_spmv_pkg::SUM_MIN;
					2: v = '0;
					3: v = '1;
					default: v = 32'sh0001_0000;
				endcase
			end
			3, 4: v = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
			default: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
		return v;
	endfunction

	task automatic build_stream();
		int n;
		// -- directed part --
		push_item(csr_spmv_pkg::OP_LOAD, 0, csr_spmv_pkg::SUM_MAX, 1'b0);
		push_item(csr_spmv_pkg::OP_LOAD, csr_spmv_pkg::VEC_DEPTH - 1,
			csr_spmv_pkg::SUM_MIN, 1'b0);
		push_item(csr_spmv_pkg::OP_LOAD, 1, 32'sh0001_0000, 1'b0);  // 1.0
		push_item(csr_spmv_pkg::OP_LOAD, 2, '1, 1'b0);              // smallest negative step
		push_item(csr_spmv_pkg::OP_LOAD, 3, '0, 1'b1);              // row_end on a load is ignored
		push_item(csr_spmv_pkg::OP_CLOSE, 0, '0, 1'b1);             // empty row, stray row_end
		push_item(csr_spmv_pkg::OP_NONZERO, 0, csr_spmv_pkg::SUM_MAX, 1'b1);  // clips high
		push_item(csr_spmv_pkg::OP_NONZERO, csr_spmv_pkg::VEC_DEPTH - 1,
			csr_spmv_pkg::SUM_MAX, 1'b1);                           // clips low
		// two huge products that cancel down to 0.5
		push_item(csr_spmv_pkg::OP_NONZERO, csr_spmv_pkg::VEC_DEPTH - 1,
			csr_spmv_pkg::SUM_MIN, 1'b0);
		push_item(csr_spmv_pkg::OP_NONZERO, 0, csr_spmv_pkg::SUM_MIN, 1'b1);
		push_item(csr_spmv_pkg::OP_NONZERO, 2, 32'sd1, 1'b1);       // floor gives -1 lsb
		push_item(csr_spmv_pkg::OP_NONZERO, 1, 32'sh0001_8000, 1'b0);
		push_item(csr_spmv_pkg::OP_NONE, 5, 32'sh1234_5678, 1'b1);  // unused opcode, no effect
		// close with a sum pending
		push_item(csr_spmv_pkg::OP_CLOSE, csr_spmv_pkg::VEC_DEPTH - 1,
			csr_spmv_pkg::SUM_MAX, 1'b0);
		push_item(csr_spmv_pkg::OP_NONZERO, 3, csr_spmv_pkg::SUM_MIN, 1'b1);  // times zero
		push_item(csr_spmv_pkg::OP_NONZERO, 2, '0, 1'b1);
		push_item(csr_spmv_pkg::OP_NONE, csr_spmv_pkg::VEC_DEPTH - 1,
			csr_spmv_pkg::SUM_MIN, 1'b0);

		// -- random part: mostly well-formed CSR rows with some broken ones --
		while (items_made < 1800) begin
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					n = $urandom_range(1, 10);
					repeat (n)
						push_item(csr_spmv_pkg::OP_LOAD,
							$urandom_range(0, csr_spmv_pkg::VEC_DEPTH - 1), pick_q16(),
							$urandom_range(0, 7) == 0);
				end
				14, 15: begin
					// row left open, then closed by the close opcode
					n = $urandom_range(1, 5);
					repeat (n)
						push_item(csr_spmv_pkg::OP_NONZERO, pick_col(), pick_q16(), 1'b0);
					push_item(csr_spmv_pkg::OP_CLOSE,
						$urandom_range(0, csr_spmv_pkg::VEC_DEPTH - 1), $urandom,
						1'($urandom_range(0, 1)));
				end
				16:
					push_item(csr_spmv_pkg::OP_CLOSE,
						$urandom_range(0, csr_spmv_pkg::VEC_DEPTH - 1), $urandom,
						1'($urandom_range(0, 1)));
				17:
					push_item(csr_spmv_pkg::OP_NONE,
						$urandom_range(0, csr_spmv_pkg::VEC_DEPTH - 1), $urandom,
						1'($urandom_range(0, 1)));
				18, 19: begin
					// vector rewritten in the middle of a row; the row goes on
					n = $urandom_range(1, 3);
					repeat (n)
						push_item(csr_spmv_pkg::OP_NONZERO, pick_col(), pick_q16(), 1'b0);
					push_item(csr_spmv_pkg::OP_LOAD,
						$urandom_range(0, csr_spmv_pkg::VEC_DEPTH - 1), pick_q16(), 1'b0);
				end
				default: begin
					n = $urandom_range(1, 8);
					for (int k = 0; k < n; k++) begin
						if ($urandom_range(0, 15) == 0)
							push_item(csr_spmv_pkg::OP_NONE, pick_col(), $urandom,
								1'($urandom_range(0, 1)));
						push_item(csr_spmv_pkg::OP_NONZERO, pick_col(), pick_q16(),
							k == n - 1);
					end
				end
			endcase
		end
	endtask

	// Driver: changes inputs on the falling edge only. Items go out in bursts
	// of random length, with random gaps (sometimes none) between bursts.
	int            burst_left;
	int            gap_left;
	stream_item_t  cur_item;

	always @(negedge clk) begin : driver
		if (arst_n && (!in_valid || item_taken)) begin
			if (gap_left > 0 || matrix_stream_q.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				in_valid <= 1'b0;
			end else begin
				cur_item = matrix_stream_q.pop_front();
				in_valid <= 1'b1;
				opcode   <= cur_item.op;
				index    <= cur_item.idx;
				value    <= cur_item.val;
				row_end  <= cur_item.last;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// Receiver: stalls follow one of four modes, redrawn at the end of each segment.
	// Twice it holds off while items keep coming, so the pipeline fills and
	// in_ready has to drop.
	int  rx_cycle;
	int  rx_holdoff;
	int  rx_seg_left;
	int  rx_mode;

	always @(negedge clk) begin : receiver
		rx_cycle++;
		if (rx_holdoff > 0) begin
			rx_holdoff--;
			out_ready <= 1'b0;
		end else if (rx_cycle == 400 || rx_cycle == 1500) begin
			rx_holdoff = 400;
			out_ready <= 1'b0;
		end else begin
			if (rx_seg_left == 0) begin
				rx_seg_left = $urandom_range(20, 200);
				rx_mode     = $urandom_range(0, 3);
			end
			rx_seg_left--;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Monitor: on the rising edge, check any result first, then apply any
	// accepted item to the predictor. A result never belongs to an item
	// accepted on the same edge, so the order of the two does not matter.
	always @(posedge clk) begin : monitor
		row_result_t   exp_row;
		stream_item_t  seen;
		if (!arst_n) begin
			item_taken = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (row_results_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result for row %0d, sum %h",
						row_index, row_sum));
				end else begin
					exp_row = row_results_q.pop_front();
					if (row_index !== exp_row.row)
						report_mismatch($sformatf("row_index %0d, expected %0d",
							row_index, exp_row.row));
					if (row_sum !== exp_row.sum)
						report_mismatch($sformatf("row %0d: row_sum %h, expected %h",
							exp_row.row, row_sum, exp_row.sum));
					if (saturated !== exp_row.sat)
						report_mismatch($sformatf("row %0d: saturated %b, expected %b",
							exp_row.row, saturated, exp_row.sat));
				end
			end
			item_taken = in_valid && in_ready;
			if (item_taken) begin
				seen.op   = csr_spmv_pkg::opcode_t'(opcode);
				seen.idx  = index;
				seen.val  = value;
				seen.last = row_end;
				accumulate_row(seen);
			end
		end
	end

	initial begin
		build_stream();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// sender done, then every expected row received, then a drain margin
		// long enough to catch a stray extra result
		while (matrix_stream_q.size() != 0 || in_valid)
			@(negedge clk);
		while (row_results_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#20000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/csr_spmv_pkg.sv
hdl/csr_sparse_matrix_vector.sv
tb/testbench.sv
